/* rtl/core/w2s_pkg.sv */
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared types and constants of the world-to-screen projector.
// ----------------------------------------------------------------------------
`default_nettype none

package w2s_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WIN_W         = 14;

	// configuration register indexes
	localparam logic CFG_WINDOW_WIDTH  = 1'b0;
	localparam logic CFG_WINDOW_HEIGHT = 1'b1;

	localparam logic [WIN_W-1:0] WINDOW_WIDTH_RST  = 14'd1920;
	localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RST = 14'd1080;

	// operation codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [3:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} w2s_in_t;

	typedef struct packed {
		logic               visible;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
	} w2s_out_t;

endpackage

`default_nettype wire

/* rtl/core/world_to_screen_projector_core.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projector_core
// Pipelined matrix transform, perspective divide and viewport mapping.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one transaction per cycle while in_ready is high.
//   A load transaction writes one column-major matrix entry and gives no
//   result. A project transaction gives exactly one result on the out channel
//   (out_valid/out_ready/out_data), in order.
//   Throughput: one transaction per cycle unless the out channel stalls. A
//   projection passes three front stages for multiply, sum and setup, one
//   stage per quotient bit of the 41-bit restoring divider, then clamp,
//   scale and saturate; the divider stages set the latency.
//   cfg_we/cfg_index/cfg_wdata write the window width and height; write them
//   only while no projection is in flight.
//   Reset clears the matrix to zero, sets the window to 1920 x 1080 and
//   empties the pipeline.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
`default_nettype none

module world_to_screen_projector_core
	import w2s_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire w2s_in_t          in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output w2s_out_t              out_data,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [WIN_W-1:0] cfg_wdata
);

	localparam int CW  = 66 - FRAC_BITS;  // clip value width
	localparam int AW  = CW + FRAC_BITS;  // scaled dividend width
	localparam int QB  = 41;              // quotient bits, up to 2^40
	localparam int XW  = CW - 1 + QB;     // divider compare width
	localparam int PW  = QB + 16;         // scaled ndc product width
	localparam int THR = ((1 << FRAC_BITS) + 5) / 10;
	localparam logic [QB-1:0] QMAX = QB'(1) << (QB - 1);
	localparam logic [1:0] ROW_COL [3] = '{2'd0, 2'd1, 2'd3};

	function automatic logic signed [31:0] sat32(input logic signed [PW:0] v);
		logic signed [31:0] r;
		if (v > $signed((PW+1)'(32'h7FFF_FFFF))) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -$signed((PW+1)'(33'h0_8000_0000))) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic pipe_en;
	logic in_acc;

	assign pipe_en  = ~out_valid | out_ready;
	assign in_ready = pipe_en;
	assign in_acc   = in_valid & pipe_en;

	// configuration and matrix store
	logic [WIN_W-1:0] ww_q, wh_q;
	logic [31:0]      mat_q [16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= WINDOW_WIDTH_RST;
			wh_q <= WINDOW_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_WINDOW_WIDTH) begin
				ww_q <= cfg_wdata;
			end else begin
				wh_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else if (in_acc && in_data.operation == OP_LOAD) begin
			mat_q[in_data.entry_index] <= in_data.entry_value;
		end
	end

	// stage 1: nine products
	logic signed [31:0] pos_v [3];
	logic               v_s1;
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] trans_s1 [3];

	assign pos_v[0] = in_data.pos_x;
	assign pos_v[1] = in_data.pos_y;
	assign pos_v[2] = in_data.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid & (in_data.operation == OP_PROJECT);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int r = 0; r < 3; r++) begin
				trans_s1[r] <= $signed(mat_q[{2'd3, ROW_COL[r]}]);
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= pos_v[k] * $signed(mat_q[{2'(k), ROW_COL[r]}]);
				end
			end
		end
	end

	// stage 2: floor, sum
	logic               v_s2;
	logic signed [63:0] sum64 [3];
	logic signed [CW-1:0] clip_s2 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum64[r] = 64'(trans_s1[r]) + (prod_s1[r][0] >>> FRAC_BITS)
				+ (prod_s1[r][1] >>> FRAC_BITS) + (prod_s1[r][2] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int r = 0; r < 3; r++) clip_s2[r] <= sum64[r][CW-1:0];
		end
	end

	// stage 3: divider setup (index 0 of the divider arrays)
	logic          dv_v_s    [QB+1];
	logic          dv_vis_s  [QB+1];
	logic [1:0]    dv_neg_s  [QB+1];
	logic [1:0]    dv_ovf_s  [QB+1];
	logic [AW-1:0] dv_r_s    [QB+1][2];
	logic [QB-1:0] dv_q_s    [QB+1][2];
	logic [CW-2:0] dv_d_s    [QB+1];

	logic [CW-1:0] absv [2];
	logic [AW-1:0] dvd  [2];
	logic [1:0]    neg_c, ovf_c;
	logic [CW-2:0] den_c;
	logic          vis_c;

	always_comb begin
		den_c = clip_s2[2][CW-2:0];
		vis_c = clip_s2[2] >= $signed(CW'(THR));
		for (int j = 0; j < 2; j++) begin
			neg_c[j] = clip_s2[j][CW-1];
			absv[j]  = neg_c[j] ? CW'(-clip_s2[j]) : clip_s2[j];
			dvd[j]   = {absv[j], {FRAC_BITS{1'b0}}};
			ovf_c[j] = {{(XW-AW){1'b0}}, dvd[j]} >= {den_c, {QB{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (pipe_en) begin
			dv_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dv_vis_s[0] <= vis_c;
			dv_neg_s[0] <= neg_c;
			dv_ovf_s[0] <= ovf_c;
			dv_d_s[0]   <= den_c;
			for (int j = 0; j < 2; j++) begin
				dv_r_s[0][j] <= dvd[j];
				dv_q_s[0][j] <= '0;
			end
		end
	end

	// divider: one quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [XW-1:0] dsh;
		logic [XW:0]   diff [2];
		logic [1:0]    qbit;

		always_comb begin
			dsh = {{QB{1'b0}}, dv_d_s[k]} << SH;
			for (int j = 0; j < 2; j++) begin
				diff[j] = {1'b0, {(XW-AW){1'b0}}, dv_r_s[k][j]} - {1'b0, dsh};
				qbit[j] = ~diff[j][XW];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (pipe_en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				dv_vis_s[k+1] <= dv_vis_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_ovf_s[k+1] <= dv_ovf_s[k];
				dv_d_s[k+1]   <= dv_d_s[k];
				for (int j = 0; j < 2; j++) begin
					dv_r_s[k+1][j] <= qbit[j] ? diff[j][AW-1:0] : dv_r_s[k][j];
					dv_q_s[k+1][j] <= {dv_q_s[k][j][QB-2:0], qbit[j]};
				end
			end
		end
	end

	// clamp and sign
	logic                v_sn, vis_sn;
	logic signed [QB:0]  ndc_sn [2];
	logic [QB-1:0]       mag [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			mag[j] = (dv_ovf_s[QB][j] || dv_q_s[QB][j] > QMAX) ? QMAX : dv_q_s[QB][j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (pipe_en) begin
			v_sn <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			vis_sn <= dv_vis_s[QB];
			for (int j = 0; j < 2; j++) begin
				ndc_sn[j] <= dv_neg_s[QB][j] ? -$signed({1'b0, mag[j]})
				                             : $signed({1'b0, mag[j]});
			end
		end
	end

	// viewport scale
	logic [WIN_W-2:0]    hw, hh;
	logic signed [14:0]  kx, ky;
	logic                v_sm, vis_sm;
	logic signed [PW-1:0] px_sm, py_sm;

	assign hw = ww_q[WIN_W-1:1];
	assign hh = wh_q[WIN_W-1:1];
	assign kx = $signed({2'b00, hw}) + 15'sd1;
	assign ky = 15'sd1 - $signed({2'b00, hh});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else if (pipe_en) begin
			v_sm <= v_sn;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			vis_sm <= vis_sn;
			px_sm  <= ndc_sn[0] * kx;
			py_sm  <= ndc_sn[1] * ky;
		end
	end

	// offset and saturate into the output register
	logic signed [PW:0] sx, sy;

	always_comb begin
		sx = (PW+1)'(px_sm) + $signed((PW+1)'(hw) << FRAC_BITS);
		sy = (PW+1)'(py_sm) + $signed((PW+1)'(hh) << FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pipe_en) begin
			out_valid <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			out_data.visible  <= vis_sm;
			out_data.screen_x <= vis_sm ? sat32(sx) : '0;
			out_data.screen_y <= vis_sm ? sat32(sy) : '0;
		end
	end

	// checks
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |-> out_data.screen_x == 0 && out_data.screen_y == 0)
		else $error("hidden result carries nonzero coordinates");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.operation == OP_LOAD |=> !v_s1)
		else $error("load transaction entered the projection pipeline");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(v_sn) && $stable(dv_v_s[0]) && $stable(v_s1))
		else $error("pipeline advanced during a stall");

endmodule

`default_nettype wire
